// ===== rtl/core/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
// Used by lpd_header_decode and length_prefixed_deframer_unit; no dependencies.
package lpd_pkg;

  // Header size in bytes and the width of the stream position counter.
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned PosW        = 32;
  localparam int unsigned LenW        = 32;
  localparam int unsigned MaxW        = 18;

  localparam logic [LenW-1:0] HeaderLen  = LenW'(HeaderBytes);
  localparam logic [PosW-1:0] HdrLastPos = PosW'(HeaderBytes - 1);

  // Reset value of the maximum message length register.
  localparam logic [MaxW-1:0] MaxBytesReset = MaxW'(4000);

  // Length modes.
  localparam logic ModeSplit16 = 1'b0;
  localparam logic ModeTotal32 = 1'b1;

  // Configuration register indexes.
  localparam logic CfgIdxLengthMode = 1'b0;
  localparam logic CfgIdxMaxBytes   = 1'b1;

  // Result of decoding a complete 4-byte header.
  typedef struct packed {
    logic [LenW-1:0] length;       // total message length, header included
    logic            error;        // oversized or short length
    logic            header_only;  // message ends on the last header byte
  } lpd_decode_t;

endpackage

// ===== rtl/core/length_prefixed_deframer_unit.sv =====
// Top level of the length-prefixed deframer: framing state and result register.
// Depends on lpd_pkg and lpd_header_decode.
//
// Usage: one received byte per word enters on the input channel (in_valid_i,
// in_stall_o, rx_byte_i). Every byte leaves as one word on the output channel
// (out_valid_o, out_stall_i) with first/last marks, and from the fourth header
// byte on with the decoded message length and an error flag.
// The output is registered: a byte accepted on the input is offered in the cycle after.
// Throughput is one byte per cycle; the result register is refilled in the
// same cycle its word is taken, so in_stall_o is high only while the output
// register is full and out_stall_i is high.
// The header word is decoded in one pass on its fourth byte; later bytes only
// compare the position counter against the stored last position.
// Reset clears the framing state to the start of a message, empties the output
// register, and sets length mode 0 and a maximum message length of 4000.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at the
// next header decode.
module length_prefixed_deframer_unit import lpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [MaxW-1:0] cfg_wdata_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      rx_byte_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      data_byte_o,
  output logic            first_of_message_o,
  output logic            last_of_message_o,
  output logic            header_done_o,
  output logic [LenW-1:0] message_length_o,
  output logic            length_error_o
);

  // Configuration registers.
  logic            length_mode_q;
  logic [MaxW-1:0] max_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_mode_q <= ModeSplit16;
      max_bytes_q   <= MaxBytesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgIdxLengthMode: length_mode_q <= cfg_wdata_i[0];
        default:          max_bytes_q   <= cfg_wdata_i;
      endcase
    end
  end

  // Handshake: accept whenever the output register is free or being emptied.
  logic out_valid_q;
  logic in_accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Framing state.
  logic [23:0]     header_shift_q, header_shift_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] total_q, total_d;
  logic [LenW-1:0] last_pos_q, last_pos_d;
  logic            err_q, err_d;

  lpd_decode_t decode;

  lpd_header_decode u_decode (
    .header_word_i (
      {header_shift_q, rx_byte_i}),
    .length_mode_i (length_mode_q),
    .max_bytes_i   (max_bytes_q),
    .decode_o      (decode)
  );

  logic            in_header;
  logic            hdr_last;
  logic            res_last;
  logic            res_done;
  logic [LenW-1:0] res_len;
  logic            res_err;

  // Per-byte result and next framing state.
  always_comb begin
    in_header = (pos_q < HdrLastPos);
    hdr_last  = (pos_q == HdrLastPos);

    header_shift_d = header_shift_q;
    total_d        = total_q;
    last_pos_d     = last_pos_q;
    err_d          = err_q;

    res_done = !in_header;
    res_len  = '0;
    res_err  = 1'b0;
    res_last = 1'b0;

    priority if (in_header) begin
      header_shift_d = {header_shift_q[15:0], rx_byte_i};
    end else if (hdr_last) begin
      header_shift_d = '0;
      total_d        = decode.length;
      last_pos_d     = decode.length - LenW'(1);
      err_d          = decode.error;
      res_len        = decode.length;
      res_err        = decode.error;
      res_last       = decode.header_only;
    end else begin
      res_len  = total_q;
      res_err  = err_q;
      res_last = (pos_q == last_pos_q);
    end

    pos_d = res_last ? '0 : pos_q + PosW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_shift_q <= '0;
      pos_q          <= '0;
      total_q        <= '0;
      last_pos_q     <= '0;
      err_q          <= 1'b0;
    end else if (in_accept) begin
      header_shift_q <= header_shift_d;
      pos_q          <= pos_d;
      total_q        <= total_d;
      last_pos_q     <= last_pos_d;
      err_q          <= err_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_byte_o        <= rx_byte_i;
      first_of_message_o <= (pos_q == '0);
      last_of_message_o  <= res_last;
      header_done_o      <= res_done;
      message_length_o   <= res_len;
      length_error_o     <= res_err;
    end
  end

  assign out_valid_o = out_valid_q;

  // Assertions.
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output register is empty");

  a_first_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && first_of_message_o) |-> !header_done_o)
    else $error("first byte of a message marked as past the header");

  a_len_before_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !header_done_o) |-> (message_length_o == '0 && !length_error_o))
    else $error("length or error shown before the header is complete");

  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_done_o) |-> (message_length_o >= HeaderLen))
    else $error("decoded message length below header size");

  a_last_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_last) |=> (pos_q == '0))
    else $error("position counter not rewound after last byte");

endmodule

// ===== rtl/core/lpd_header_decode.sv =====
// Combinational decode of a complete header word into length and error flags.
// Depends on lpd_pkg.
module lpd_header_decode import lpd_pkg::*; (
  input  logic [31:0]     header_word_i,
  input  logic            length_mode_i,
  input  logic [MaxW-1:0] max_bytes_i,
  output lpd_decode_t     decode_o
);

  logic [LenW-1:0] len_split;
  logic            too_short;
  logic [LenW-1:0] len;
  logic            header_only;

  // Two big-endian 16-bit lengths plus the header.
  assign len_split = HeaderLen + LenW'(header_word_i[31:16]) + LenW'(header_word_i[15:0]);

  // A 32-bit length below the header size is flagged and taken as the header alone.
  assign too_short = (header_word_i < HeaderLen);

  always_comb begin
    unique case (length_mode_i)
      ModeSplit16: begin
        len         = len_split;
        header_only = (header_word_i == '0);
      end
      default: begin
        len         = too_short ? HeaderLen : header_word_i;
        header_only = (header_word_i <= HeaderLen);
      end
    endcase
  end

  always_comb begin
    decode_o.length      = len;
    decode_o.header_only = header_only;
    decode_o.error       = ((length_mode_i == ModeTotal32) && too_short) ||
                           (len > LenW'(max_bytes_i));
  end

endmodule
